/* rtl/pavf_pkg.sv */
// Shared constants, types and helper functions for the position angle pipeline.
`timescale 1ns / 1ps
package pavf_pkg;

  localparam int COMPONENT_WIDTH_DEF     = 32;
  localparam int ANGLE_FRACTION_BITS_DEF = 29;

  // normalized magnitude width, signed component width, output width
  localparam int MAG_W     = 31;
  localparam int COMP_W    = 32;
  localparam int BEARING_W = 32;
  localparam int LEN_W     = 32;
  localparam int NUM_W     = 62;
  localparam int REM_W     = 33;
  localparam int LANES     = 3;
  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS  = 31;
  localparam int Z_W        = 66;

  localparam logic signed [63:0] PI_Q61         = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] QUARTER_PI_Q61 = 64'sh1921FB54442D1847;

  // one CORDIC vectoring cell's payload
  typedef struct packed {
    logic              zero;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [Z_W-1:0] z;
  } cordic_t;

  // count leading zeros of a 64-bit word in six halving steps
  function automatic logic [5:0] lzc64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [5:0]  n;
    v = v_in;
    n = '0;
    if (v[63:32] == '0) begin n[5] = 1'b1; v = v << 32; end
    if (v[63:48] == '0) begin n[4] = 1'b1; v = v << 16; end
    if (v[63:56] == '0) begin n[3] = 1'b1; v = v << 8; end
    if (v[63:60] == '0) begin n[2] = 1'b1; v = v << 4; end
    if (v[63:62] == '0) begin n[1] = 1'b1; v = v << 2; end
    if (v[63] == 1'b0) begin n[0] = 1'b1; end
    return n;
  endfunction

  // arctangent of 2^-i in Q61 from its power series, evaluated at elaboration
  function automatic logic signed [63:0] atan_q61(input int i);
    logic signed [63:0] acc;
    logic [63:0]        term;
    int                 e;
    acc = '0;
    if (i == 0) begin
      return QUARTER_PI_Q61;
    end
    for (int k = 0; k < 32; k++) begin
      if ((2 * k + 1) * i <= 62) begin
        e    = 62 - (2 * k + 1) * i;
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
    end
    return (acc + 64'sd1) >>> 1;
  endfunction

endpackage

/* rtl/pavf_sqrt_cell.sv */
// One bit-pair step of the pipelined integer square root.
`timescale 1ns / 1ps
module pavf_sqrt_cell
  import pavf_pkg::*;
#(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [63:0]   n_i,
  input  logic [63:0]   res_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [63:0]   n_o,
  output logic [63:0]   res_o,
  output logic [SW-1:0] side_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  logic [63:0] n_d, res_d;
  logic        valid_q;
  logic [63:0] n_q, res_q;
  logic [SW-1:0] side_q;

  // try to subtract the next odd term
  always_comb begin
    trial = res_i + BIT;
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign res_o   = res_q;
  assign side_o  = side_q;

endmodule

/* rtl/pavf_div_cell.sv */
// One quotient bit of the pipelined restoring divider, three lanes wide.
`timescale 1ns / 1ps
module pavf_div_cell
  import pavf_pkg::*;
#(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LEN_W-1:0]             len_i,
  input  logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  logic [LANES-1:0][REM_W-1:0]  rem_i,
  input  logic [LANES-1:0][MAG_W-1:0]  quo_i,
  input  logic [SW-1:0]                side_i,
  output logic                         valid_o,
  output logic [LEN_W-1:0]             len_o,
  output logic [LANES-1:0][NUM_W-1:0]  num_o,
  output logic [LANES-1:0][REM_W-1:0]  rem_o,
  output logic [LANES-1:0][MAG_W-1:0]  quo_o,
  output logic [SW-1:0]                side_o
);

  localparam int NBIT = MAG_W - 1 - STEP;

  logic [LANES-1:0][REM_W-1:0] shifted;
  logic [LANES-1:0][REM_W-1:0] rem_d;
  logic [LANES-1:0][MAG_W-1:0] quo_d;
  logic                        valid_q;
  logic [LEN_W-1:0]            len_q;
  logic [LANES-1:0][NUM_W-1:0] num_q;
  logic [LANES-1:0][REM_W-1:0] rem_q;
  logic [LANES-1:0][MAG_W-1:0] quo_q;
  logic [SW-1:0]               side_q;

  // bring down the next numerator bit and subtract where it fits
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      shifted[j] = {rem_i[j][REM_W-2:0], num_i[j][NBIT]};
      if (shifted[j] >= {1'b0, len_i}) begin
        rem_d[j] = shifted[j] - {1'b0, len_i};
        quo_d[j] = {quo_i[j][MAG_W-2:0], 1'b1};
      end else begin
        rem_d[j] = shifted[j];
        quo_d[j] = {quo_i[j][MAG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q  <= len_i;
      num_q  <= num_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

/* rtl/pavf_cordic_cell.sv */
// One vectoring rotation of the pipelined CORDIC arctangent.
`timescale 1ns / 1ps
module pavf_cordic_cell
  import pavf_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    valid_o,
  output cordic_t data_o
);

  localparam logic signed [63:0]  ATAN   = atan_q61(STEP);
  localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(ATAN);

  logic signed [63:0] dx, dy;
  cordic_t data_d;
  cordic_t data_q;
  logic    valid_q;

  // rotate toward the positive x axis
  always_comb begin
    dx = data_i.y >>> STEP;
    dy = data_i.x >>> STEP;
    data_d      = data_i;
    if (data_i.y >= 0) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ATAN_Z;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ATAN_Z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/position_angle_from_vectors_core.sv */
// Top level of the position angle (bearing) pipeline.
`timescale 1ns / 1ps
// Bearing of a second 3-D direction seen from a first, both given as signed
// fixed-point vectors on any common scale; the result is radians in signed
// Q3.ANGLE_FRACTION_BITS, zero for coincident or degenerate input. The block
// is a fully pipelined chain: a 32-cell square root, a 31-cell divider that
// makes the first vector unit length, a few multiply stages and an
// (ANGLE_FRACTION_BITS+4)-cell CORDIC. It accepts one request per clock
// unless the output stalls; a stalled output holds the whole pipeline.
// No reset sweep is needed.
module position_angle_from_vectors_core
  import pavf_pkg::*;
#(
  parameter int COMPONENT_WIDTH     = COMPONENT_WIDTH_DEF,
  parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0] first_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] first_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] first_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] second_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] second_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] second_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [BEARING_W-1:0]       bearing_o
);

  localparam int CW      = COMPONENT_WIDTH;
  localparam int STEPS   = ANGLE_FRACTION_BITS + 4;
  localparam int RSHIFT  = 61 - ANGLE_FRACTION_BITS;
  localparam int SQ_SW   = 1 + LANES + LANES * MAG_W + LANES * COMP_W;
  localparam int DV_SW   = 1 + LANES + LANES * COMP_W;
  localparam logic signed [Z_W-1:0] PI_Z   = Z_W'(PI_Q61);
  localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(1) <<< (RSHIFT - 1);

  logic adv;
  logic out_valid_q;
  logic signed [BEARING_W-1:0] bearing_q;

  // global advance: move when the output slot is free or being taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage A: sign/magnitude and common normalization
  logic [LANES-1:0][CW-1:0] raw_a, raw_b;
  logic [LANES-1:0][CW-1:0] mag_a, mag_b;
  logic [LANES-1:0][63:0]   ext_a, ext_b;
  logic [LANES-1:0]         neg_a, neg_b;
  logic [5:0]               lz_a, lz_b;
  logic [LANES-1:0][MAG_W-1:0] nrm_a, nrm_b;
  logic                        va_q;
  logic [LANES-1:0][MAG_W-1:0] amag_a_q, bmag_a_q;
  logic [LANES-1:0]            asg_a_q, bsg_a_q;

  assign raw_a = {first_z_i, first_y_i, first_x_i};
  assign raw_b = {second_z_i, second_y_i, second_x_i};

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      neg_a[j] = raw_a[j][CW-1];
      neg_b[j] = raw_b[j][CW-1];
      mag_a[j] = neg_a[j] ? (~raw_a[j] + CW'(1)) : raw_a[j];
      mag_b[j] = neg_b[j] ? (~raw_b[j] + CW'(1)) : raw_b[j];
      ext_a[j] = 64'(mag_a[j]);
      ext_b[j] = 64'(mag_b[j]);
    end
    lz_a = lzc64(ext_a[0] | ext_a[1] | ext_a[2]);
    lz_b = lzc64(ext_b[0] | ext_b[1] | ext_b[2]);
    for (int j = 0; j < LANES; j++) begin
      nrm_a[j] = MAG_W'((ext_a[j] << lz_a) >> 33);
      nrm_b[j] = MAG_W'((ext_b[j] << lz_b) >> 33);
    end
  end

  // ---------------- stage B: squares of the first vector
  logic                        vb_q;
  logic [LANES-1:0][61:0]      sq_b_q;
  logic [LANES-1:0][MAG_W-1:0] amag_b_q;
  logic [LANES-1:0]            asg_b_q;
  logic [LANES-1:0][COMP_W-1:0] bval_b_q;
  logic [LANES-1:0][COMP_W-1:0] bval_a;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      bval_a[j] = bsg_a_q[j] ? (COMP_W'(0) - COMP_W'(bmag_a_q[j])) : COMP_W'(bmag_a_q[j]);
    end
  end

  // ---------------- stage C: squared length
  logic                        vc_q;
  logic [63:0]                 l2_c_q;
  logic [SQ_SW-1:0]            side_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      amag_a_q <= nrm_a;
      bmag_a_q <= nrm_b;
      asg_a_q  <= neg_a;
      bsg_a_q  <= neg_b;
      for (int j = 0; j < LANES; j++) begin
        sq_b_q[j] <= 62'(amag_a_q[j]) * 62'(amag_a_q[j]);
      end
      amag_b_q <= amag_a_q;
      asg_b_q  <= asg_a_q;
      bval_b_q <= bval_a;
      l2_c_q   <= 64'(sq_b_q[0]) + 64'(sq_b_q[1]) + 64'(sq_b_q[2]);
      side_c_q <= {(sq_b_q == '0), asg_b_q, amag_b_q, bval_b_q};
    end
  end

  // ---------------- square root chain
  logic [SQRT_CELLS:0]            sv;
  logic [SQRT_CELLS:0][63:0]      sn, sres;
  logic [SQRT_CELLS:0][SQ_SW-1:0] sside;

  assign sv[0]    = vc_q;
  assign sn[0]    = l2_c_q;
  assign sres[0]  = '0;
  assign sside[0] = side_c_q;

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    pavf_sqrt_cell #(.STEP(g), .SW(SQ_SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv[g]),
      .n_i     (sn[g]),
      .res_i   (sres[g]),
      .side_i  (sside[g]),
      .valid_o (sv[g+1]),
      .n_o     (sn[g+1]),
      .res_o   (sres[g+1]),
      .side_o  (sside[g+1])
    );
  end

  // ---------------- stage D: rounded numerators for the unit vector
  logic                         l2z_s;
  logic [LANES-1:0]             asg_s;
  logic [LANES-1:0][MAG_W-1:0]  amag_s;
  logic [LANES-1:0][COMP_W-1:0] bval_s;
  logic [LEN_W-1:0]             len_s;
  logic                         vd_q;
  logic [LEN_W-1:0]             len_d_q;
  logic [LANES-1:0][NUM_W-1:0]  num_d_q;
  logic [LANES-1:0][REM_W-1:0]  rem_d_q;
  logic [DV_SW-1:0]             side_d_q;

  assign {l2z_s, asg_s, amag_s, bval_s} = sside[SQRT_CELLS];
  assign len_s = sres[SQRT_CELLS][LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= sv[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_d_q  <= len_s;
      side_d_q <= {l2z_s, asg_s, bval_s};
      for (int j = 0; j < LANES; j++) begin
        num_d_q[j] <= (NUM_W'(amag_s[j]) << 30) + NUM_W'(len_s >> 1);
        rem_d_q[j] <= REM_W'(((NUM_W'(amag_s[j]) << 30) + NUM_W'(len_s >> 1)) >> MAG_W);
      end
    end
  end

  // ---------------- divider chain
  logic [DIV_CELLS:0]                         dv;
  logic [DIV_CELLS:0][LEN_W-1:0]              dlen;
  logic [DIV_CELLS:0][LANES-1:0][NUM_W-1:0]   dnum;
  logic [DIV_CELLS:0][LANES-1:0][REM_W-1:0]   drem;
  logic [DIV_CELLS:0][LANES-1:0][MAG_W-1:0]   dquo;
  logic [DIV_CELLS:0][DV_SW-1:0]              dside;

  assign dv[0]    = vd_q;
  assign dlen[0]  = len_d_q;
  assign dnum[0]  = num_d_q;
  assign drem[0]  = rem_d_q;
  assign dquo[0]  = '0;
  assign dside[0] = side_d_q;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    pavf_div_cell #(.STEP(g), .SW(DV_SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv[g]),
      .len_i   (dlen[g]),
      .num_i   (dnum[g]),
      .rem_i   (drem[g]),
      .quo_i   (dquo[g]),
      .side_i  (dside[g]),
      .valid_o (dv[g+1]),
      .len_o   (dlen[g+1]),
      .num_o   (dnum[g+1]),
      .rem_o   (drem[g+1]),
      .quo_o   (dquo[g+1]),
      .side_o  (dside[g+1])
    );
  end

  // ---------------- stages E..I: unit vector, products, sine and cosine terms
  logic                         l2z_v;
  logic [LANES-1:0]             asg_v;
  logic [LANES-1:0][COMP_W-1:0] bval_v;

  assign {l2z_v, asg_v, bval_v} = dside[DIV_CELLS];

  logic ve_q, vf_q, vg_q, vh_q, vi_q;
  logic signed [LANES-1:0][COMP_W-1:0] u_e_q, b_e_q;
  logic signed [63:0] uu0_f_q, uu1_f_q, bu0_f_q, bu1_f_q, s1_f_q, s0_f_q;
  logic signed [COMP_W-1:0] b2_f_q, u2_f_q, b2_g_q, u2_g_q;
  logic signed [33:0] p_g_q, d_g_q;
  logic signed [63:0] s_g_q, s_h_q, s_i_q, bp_h_q, ud_h_q, c_i_q;
  logic signed [63:0] psum, dsum;
  logic signed [65:0] bp_full, ud_full;

  always_comb begin
    psum    = uu0_f_q + uu1_f_q + 64'sd536870912;
    dsum    = bu0_f_q + bu1_f_q + 64'sd536870912;
    bp_full = 66'(b2_g_q) * 66'(p_g_q);
    ud_full = 66'(u2_g_q) * 66'(d_g_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
    end else if (adv) begin
      ve_q <= dv[DIV_CELLS];
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // E: signed unit components, zero for a zero first vector
      for (int j = 0; j < LANES; j++) begin
        if (l2z_v) u_e_q[j] <= '0;
        else if (asg_v[j]) u_e_q[j] <= COMP_W'(0) - COMP_W'(dquo[DIV_CELLS][j]);
        else u_e_q[j] <= COMP_W'(dquo[DIV_CELLS][j]);
      end
      b_e_q <= bval_v;
      // F: signed products of the lane elements
      uu0_f_q <= 64'($signed(u_e_q[0])) * 64'($signed(u_e_q[0]));
      uu1_f_q <= 64'($signed(u_e_q[1])) * 64'($signed(u_e_q[1]));
      bu0_f_q <= 64'($signed(b_e_q[0])) * 64'($signed(u_e_q[0]));
      bu1_f_q <= 64'($signed(b_e_q[1])) * 64'($signed(u_e_q[1]));
      s1_f_q  <= 64'($signed(b_e_q[1])) * 64'($signed(u_e_q[0]));
      s0_f_q  <= 64'($signed(b_e_q[0])) * 64'($signed(u_e_q[1]));
      b2_f_q  <= b_e_q[2];
      u2_f_q  <= u_e_q[2];
      // G: pole projection terms and sine term
      p_g_q  <= 34'(psum >>> 30);
      d_g_q  <= 34'(dsum >>> 30);
      s_g_q  <= s1_f_q - s0_f_q;
      b2_g_q <= b2_f_q;
      u2_g_q <= u2_f_q;
      // H: cosine products
      bp_h_q <= 64'(bp_full);
      ud_h_q <= 64'(ud_full);
      s_h_q  <= s_g_q;
      // I: cosine term
      c_i_q  <= bp_h_q - ud_h_q;
      s_i_q  <= s_h_q;
    end
  end

  // ---------------- stages J, K: quadrant fold and normalization
  logic        vj_q, vk_q;
  logic        zero_j_q, yneg_j_q;
  logic [63:0] ms_j_q, mc_j_q;
  logic signed [Z_W-1:0] z_j_q;
  logic [5:0]  lz_sc;
  logic [63:0] nms, nmc;
  cordic_t     ck_q;

  always_comb begin
    lz_sc = lzc64(ms_j_q | mc_j_q);
    nms   = (ms_j_q << lz_sc) >> 5;
    nmc   = (mc_j_q << lz_sc) >> 5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vj_q <= 1'b0;
      vk_q <= 1'b0;
    end else if (adv) begin
      vj_q <= vi_q;
      vk_q <= vj_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_j_q <= (s_i_q == '0) && (c_i_q == '0);
      ms_j_q   <= s_i_q[63] ? (64'd0 - 64'(s_i_q)) : 64'(s_i_q);
      mc_j_q   <= c_i_q[63] ? (64'd0 - 64'(c_i_q)) : 64'(c_i_q);
      // fold a negative cosine term into the start angle
      if (c_i_q[63]) begin
        z_j_q    <= s_i_q[63] ? -PI_Z : PI_Z;
        yneg_j_q <= !s_i_q[63];
      end else begin
        z_j_q    <= '0;
        yneg_j_q <= s_i_q[63];
      end
      ck_q.zero <= zero_j_q;
      ck_q.x    <= $signed(nmc);
      ck_q.y    <= yneg_j_q ? -$signed(nms) : $signed(nms);
      ck_q.z    <= z_j_q;
    end
  end

  // ---------------- CORDIC chain
  logic    [STEPS:0] cv;
  cordic_t [STEPS:0] cd;

  assign cv[0] = vk_q;
  assign cd[0] = ck_q;

  for (genvar g = 0; g < STEPS; g++) begin : g_cordic
    pavf_cordic_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cv[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .data_o  (cd[g+1])
    );
  end

  // ---------------- output: clamp, round, hold until taken
  logic signed [Z_W-1:0] z_cl, z_rnd;

  always_comb begin
    if (cd[STEPS].zero) z_cl = '0;
    else if (cd[STEPS].z > PI_Z) z_cl = PI_Z;
    else if (cd[STEPS].z < -PI_Z) z_cl = -PI_Z;
    else z_cl = cd[STEPS].z;
    z_rnd = (z_cl + HALF_Z) >>> RSHIFT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cv[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bearing_q <= z_rnd[BEARING_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign bearing_o   = bearing_q;

endmodule
